FILE: rtl/core/sqsk_pkg.sv
// Package for the quintic spline kernel: widths, region codes, register indexes.
// No dependencies.
package sqsk_pkg;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int CSR_ADDR_W     = 4;
   localparam int REG_W          = 3;

   typedef enum logic [REG_W-1:0] {
      REGION_INNER  = 3'd0,
      REGION_MIDDLE = 3'd1,
      REGION_OUTER  = 3'd2,
      REGION_OUTSIDE = 3'd3,
      REGION_ZERO   = 3'd4
   } region_type;

   typedef enum logic [1:0] {
      CSR_RECIP = 2'd0,
      CSR_WFACT = 2'd1,
      CSR_GFACT = 2'd2
   } csr_index_type;
endpackage

FILE: rtl/core/sqsk_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on sqsk_pkg.
module sqsk_divider import sqsk_pkg::*; #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 32,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);
   logic              vld_ff  [NUM_W+1];
   logic [NUM_W-1:0]  quo_ff  [NUM_W+1];
   logic [DEN_W:0]    rem_ff  [NUM_W+1];
   logic [DEN_W-1:0]  den_ff  [NUM_W+1];
   logic [SIDE_W-1:0] side_ff [NUM_W+1];

   always_comb begin
      vld_ff[0]  = in_valid;
      quo_ff[0]  = in_num;
      rem_ff[0]  = '0;
      den_ff[0]  = in_den;
      side_ff[0] = in_side;
   end

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [DEN_W:0]   sh_in;
      logic [DEN_W+1:0] diff_in;
      always_comb begin
         sh_in   = {rem_ff[s][DEN_W-1:0], quo_ff[s][NUM_W-1]};
         diff_in = {1'b0, sh_in} - {2'b0, den_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (advance) begin
            if (!diff_in[DEN_W+1]) begin
               rem_ff[s+1] <= diff_in[DEN_W:0];
               quo_ff[s+1] <= {quo_ff[s][NUM_W-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= sh_in;
               quo_ff[s+1] <= {quo_ff[s][NUM_W-2:0], 1'b0};
            end
            den_ff[s+1]  <= den_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[NUM_W];
   assign out_quot  = quo_ff[NUM_W];
   assign out_side  = side_ff[NUM_W];
endmodule

FILE: rtl/core/sph_quintic_spline_kernel.sv
// Quintic spline SPH kernel, fully pipelined top level.
// Depends on sqsk_pkg and sqsk_divider.
//
//  channel  | ports                          | direction
//  request  | req_valid/req_stall + fields   | in
//  result   | rsp_valid/rsp_stall + fields   | out
//  csr      | APB p* signals, write/read     | in/out
//
// One request per cycle while not stalled; the pipeline is dominated by the
// 2*DATA_WIDTH+6 stage gradient divider.
// Synchronous active-high reset clears all valid bits; csr registers reset to defaults.
// A stall freezes the whole pipe (global enable); req_stall is high only when
// the output stage holds a result and rsp_stall is high.
module sph_quintic_spline_kernel import sqsk_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [DATA_WIDTH-1:0]        req_pair_distance,
   input  logic signed [DATA_WIDTH-1:0] req_sep_x,
   input  logic signed [DATA_WIDTH-1:0] req_sep_y,
   input  logic signed [DATA_WIDTH-1:0] req_sep_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [DATA_WIDTH-1:0]        rsp_kernel_weight,
   output logic signed [DATA_WIDTH-1:0] rsp_grad_x,
   output logic signed [DATA_WIDTH-1:0] rsp_grad_y,
   output logic signed [DATA_WIDTH-1:0] rsp_grad_z,
   output logic [REG_W-1:0]             rsp_region,
   output logic                         rsp_saturated,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [CSR_ADDR_W-1:0]        paddr,
   input  logic [DATA_WIDTH-1:0]        pwdata,
   output logic [DATA_WIDTH-1:0]        prdata,
   output logic                         pready
);
   localparam int DW = DATA_WIDTH;
   localparam int FB = FRAC_BITS;
   localparam int W2 = 2*DW;
   localparam logic [DW-1:0] ONE   = DW'(1) << FB;
   localparam logic [DW-1:0] THIRD = DW'((64'd1 << FB) / 3);
   localparam logic [DW-1:0] TWO3  = DW'((64'd2 << FB) / 3);
   localparam logic [DW-1:0] SMAX  = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] SMIN  = {1'b1, {(DW-1){1'b0}}};
   localparam int NST = 12;  // stages before the divider

   // ---------------- configuration ----------------
   logic [DW-1:0] recip_ff, wfact_ff, gfact_ff;
   logic          csr_wr;
   logic [1:0]    csr_idx;
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[3:2];
   always_ff @(posedge clock) begin
      if (reset) begin
         recip_ff <= ONE;
         wfact_ff <= ONE;
         gfact_ff <= DW'(5) << FB;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_RECIP: recip_ff <= pwdata;
            CSR_WFACT: wfact_ff <= pwdata;
            CSR_GFACT: gfact_ff <= pwdata;
            default: ;
         endcase
      end
   end
   always_comb begin
      case (csr_idx)
         CSR_RECIP: prdata = recip_ff;
         CSR_WFACT: prdata = wfact_ff;
         CSR_GFACT: prdata = gfact_ff;
         default:   prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // generic per-stage valid and carried inputs
   logic          v_ff   [NST+1];
   logic [DW-1:0] d_ff   [NST+1];
   logic [DW-1:0] sx_ff  [NST+1], sy_ff [NST+1], sz_ff [NST+1];
   always_comb begin
      v_ff[0]  = req_valid;
      d_ff[0]  = req_pair_distance;
      sx_ff[0] = req_sep_x;
      sy_ff[0] = req_sep_y;
      sz_ff[0] = req_sep_z;
   end
   for (genvar s = 0; s < NST; s++) begin : g_carry
      always_ff @(posedge clock) begin
         if (reset) v_ff[s+1] <= 1'b0;
         else if (advance) v_ff[s+1] <= v_ff[s];
         if (advance) begin
            d_ff[s+1]  <= d_ff[s];
            sx_ff[s+1] <= sx_ff[s];
            sy_ff[s+1] <= sy_ff[s];
            sz_ff[s+1] <= sz_ff[s];
         end
      end
   end

   // stage 1: q product
   logic [W2-1:0] qp_ff;
   always_ff @(posedge clock) if (advance) qp_ff <= W2'(d_ff[0]) * W2'(recip_ff);

   // stage 2: q, region, bases
   logic [REG_W-1:0] reg2_ff;
   logic [DW-1:0]    bu2_ff, bv2_ff, bw2_ff;
   always_ff @(posedge clock) begin
      logic [W2-1:0] qw;
      logic [DW-1:0] q;
      logic          outside;
      logic [DW+1:0] q3;
      if (advance) begin
         qw      = qp_ff >> FB;
         outside = qw > W2'(ONE);
         q       = outside ? '0 : qw[DW-1:0];
         q3      = (DW+2)'(q) * 3;
         if (outside) reg2_ff <= REGION_OUTSIDE;
         else if (q3 < (DW+2)'(ONE)) reg2_ff <= REGION_INNER;
         else if (q3 < ((DW+2)'(ONE) << 1)) reg2_ff <= REGION_MIDDLE;
         else reg2_ff <= REGION_OUTER;
         bu2_ff <= ONE - q;
         bv2_ff <= TWO3 - q;
         bw2_ff <= THIRD - q;
      end
   end

   // stages 3..6: powers x^2,x^3,x^4,x^5 (wrap modulo 2^DW)
   logic [DW-1:0] pu_ff [4], pv_ff [4], pw_ff [4];
   logic [DW-1:0] xu_ff [4], xv_ff [4], xw_ff [4];
   logic [REG_W-1:0] rg_ff [4];
   logic [DW-1:0] u4_ff, v4_ff, w4_ff;
   always_comb begin
      pu_ff[0] = bu2_ff; pv_ff[0] = bv2_ff; pw_ff[0] = bw2_ff;
      xu_ff[0] = bu2_ff; xv_ff[0] = bv2_ff; xw_ff[0] = bw2_ff;
      rg_ff[0] = reg2_ff;
   end
   for (genvar p = 0; p < 3; p++) begin : g_pow
      always_ff @(posedge clock) begin
         if (advance) begin
            pu_ff[p+1] <= DW'((W2'(pu_ff[p]) * W2'(xu_ff[p])) >> FB);
            pv_ff[p+1] <= DW'((W2'(pv_ff[p]) * W2'(xv_ff[p])) >> FB);
            pw_ff[p+1] <= DW'((W2'(pw_ff[p]) * W2'(xw_ff[p])) >> FB);
            xu_ff[p+1] <= xu_ff[p]; xv_ff[p+1] <= xv_ff[p]; xw_ff[p+1] <= xw_ff[p];
            rg_ff[p+1] <= rg_ff[p];
         end
      end
   end
   // stage 6: fifth power
   logic [DW-1:0] u5_ff, v5_ff, w5_ff;
   logic [REG_W-1:0] rg6_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         u4_ff <= pu_ff[3]; v4_ff <= pv_ff[3]; w4_ff <= pw_ff[3];
         u5_ff <= DW'((W2'(pu_ff[3]) * W2'(xu_ff[3])) >> FB);
         v5_ff <= DW'((W2'(pv_ff[3]) * W2'(xv_ff[3])) >> FB);
         w5_ff <= DW'((W2'(pw_ff[3]) * W2'(xw_ff[3])) >> FB);
         rg6_ff <= rg_ff[3];
      end
   end

   // stage 7: sums (signed, DW+5 bits suffices)
   localparam int SW = DW + 6;
   logic signed [SW-1:0] s5_ff, s4_ff;
   logic [REG_W-1:0]     rg7_ff;
   always_ff @(posedge clock) begin
      logic signed [SW-1:0] a5, a4;
      if (advance) begin
         a5 = $signed(SW'(u5_ff));
         a4 = $signed(SW'(u4_ff));
         if (rg6_ff == REGION_INNER || rg6_ff == REGION_MIDDLE) begin
            a5 = a5 - $signed(SW'(v5_ff)) * 6;
            a4 = a4 - $signed(SW'(v4_ff)) * 6;
         end
         if (rg6_ff == REGION_INNER) begin
            a5 = a5 + $signed(SW'(w5_ff)) * 15;
            a4 = a4 + $signed(SW'(w4_ff)) * 15;
         end
         s5_ff  <= a5;
         s4_ff  <= a4;
         rg7_ff <= rg6_ff;
      end
   end

   // stage 8: weight product and gradient numerator product
   logic [W2+5:0] wp_ff;
   logic          wneg_ff;
   logic [W2+5:0] gp_ff;
   logic          cneg_ff;
   logic [REG_W-1:0] rg8_ff;
   always_ff @(posedge clock) begin
      logic [DW-1:0] gmag;
      logic [SW-1:0] s4m;
      if (advance) begin
         gmag    = gfact_ff[DW-1] ? (~gfact_ff + 1'b1) : gfact_ff;
         s4m     = s4_ff[SW-1] ? SW'(-s4_ff) : SW'(s4_ff);
         wneg_ff <= s5_ff[SW-1];
         wp_ff   <= (W2+6)'(wfact_ff) * (W2+6)'(SW'(s5_ff));
         gp_ff   <= (W2+6)'(gmag) * (W2+6)'(s4m);
         cneg_ff <= gfact_ff[DW-1] ^ s4_ff[SW-1];
         rg8_ff  <= rg7_ff;
      end
   end

   // stage 9: weight clip; gradient terms ride along
   logic [DW-1:0]    wt9_ff;
   logic             wsat9_ff;
   logic [W2+5:0]    gp9_ff;
   logic             cn9_ff;
   logic [REG_W-1:0] rg9_ff;
   always_ff @(posedge clock) begin
      logic [W2+5:0] sh;
      if (advance) begin
         gp9_ff <= gp_ff;
         cn9_ff <= cneg_ff;
         rg9_ff <= rg8_ff;
         sh = wp_ff >> FB;
         if (rg8_ff == REGION_OUTSIDE) begin
            wt9_ff <= '0; wsat9_ff <= 1'b0;
         end else if (wneg_ff) begin
            wt9_ff <= '0; wsat9_ff <= 1'b1;
         end else if (sh > (W2+6)'({DW{1'b1}})) begin
            wt9_ff <= '1; wsat9_ff <= 1'b1;
         end else begin
            wt9_ff <= sh[DW-1:0]; wsat9_ff <= 1'b0;
         end
      end
   end

   // stages 10..12: plain delay to align with carry stage NST
   logic [DW-1:0]    wt_ff [3];
   logic             ws_ff [3];
   logic [W2+5:0]    gq_ff [3];
   logic             cn_ff [3];
   logic [REG_W-1:0] rr_ff [3];
   always_ff @(posedge clock) begin
      if (advance) begin
         wt_ff[0] <= wt9_ff; ws_ff[0] <= wsat9_ff; gq_ff[0] <= gp9_ff;
         cn_ff[0] <= cn9_ff; rr_ff[0] <= rg9_ff;
         for (int i = 0; i < 2; i++) begin
            wt_ff[i+1] <= wt_ff[i]; ws_ff[i+1] <= ws_ff[i]; gq_ff[i+1] <= gq_ff[i];
            cn_ff[i+1] <= cn_ff[i]; rr_ff[i+1] <= rr_ff[i];
         end
      end
   end
   // every stage-9 register goes through 3 more, so index 2 lines up with carry 12
   // (qp=1, stage2=2, pow 3..5, fifth=6, sums=7, products=8, clip=9, delay 10..12)

   // ---------------- divider ----------------
   localparam int NUMW = W2 + 6;
   localparam int SIDEW = DW*4 + DW + 1 + 1 + REG_W;
   logic [SIDEW-1:0] dside_in, dside_out;
   logic             dv_out;
   logic [NUMW-1:0]  coef;
   logic [DW-1:0]    dd;
   assign dd = (d_ff[NST] == '0) ? DW'(1) : d_ff[NST];
   assign dside_in = {d_ff[NST], sx_ff[NST], sy_ff[NST], sz_ff[NST], wt_ff[2], ws_ff[2],
                      cn_ff[2], rr_ff[2]};
   sqsk_divider #(.NUM_W(NUMW), .DEN_W(DW), .SIDE_W(SIDEW)) u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(v_ff[NST]), .in_num(gq_ff[2]), .in_den(dd), .in_side(dside_in),
      .out_valid(dv_out), .out_quot(coef), .out_side(dside_out)
   );

   logic [DW-1:0]    o_d, o_sx, o_sy, o_sz, o_wt;
   logic             o_ws, o_cn;
   logic [REG_W-1:0] o_rg;
   assign {o_d, o_sx, o_sy, o_sz, o_wt, o_ws, o_cn, o_rg} = dside_out;

   // post stage A: per-component partial products (coef low word and the next
   // FB bits; above that a nonzero component clips unless d is zero or q is outside)
   logic             pa_v_ff;
   logic [W2-1:0]    pr_ff [3];
   logic [DW+FB-1:0] prh_ff [3];
   logic             pn_ff [3], pz_ff [3];
   logic             chi_ff, czero_ff;
   logic [DW-1:0]    a_sep_ff [3], a_d_ff, a_wt_ff;
   logic             a_ws_ff;
   logic [REG_W-1:0] a_rg_ff;
   always_ff @(posedge clock) begin
      logic [DW-1:0] sv [3];
      logic [DW-1:0] sm;
      if (reset) pa_v_ff <= 1'b0;
      else if (advance) pa_v_ff <= dv_out;
      if (advance) begin
         sv[0] = o_sx; sv[1] = o_sy; sv[2] = o_sz;
         for (int k = 0; k < 3; k++) begin
            sm = sv[k][DW-1] ? (~sv[k] + 1'b1) : sv[k];
            pr_ff[k]  <= W2'(coef[DW-1:0]) * W2'(sm);
            prh_ff[k] <= (DW+FB)'(coef[DW+FB-1:DW]) * (DW+FB)'(sm);
            pn_ff[k]  <= o_cn ^ sv[k][DW-1];
            pz_ff[k]  <= (sm == '0);
            a_sep_ff[k] <= sv[k];
         end
         chi_ff   <= coef[NUMW-1:DW+FB] != '0;
         czero_ff <= coef == '0;
         a_d_ff   <= o_d;
         a_wt_ff  <= o_wt;
         a_ws_ff  <= o_ws;
         a_rg_ff  <= o_rg;
      end
   end

   // post stage B: sum, clip, sign, output register
   logic             out_v_ff;
   logic [DW-1:0]    out_wt_ff, out_g_ff [3];
   logic [REG_W-1:0] out_rg_ff;
   logic             out_sat_ff;
   always_ff @(posedge clock) begin
      logic [W2+FB-1:0] full;
      logic [W2-1:0] sh;
      logic [DW-1:0] lim, m;
      logic          sat;
      if (reset) out_v_ff <= 1'b0;
      else if (advance) out_v_ff <= pa_v_ff;
      if (advance) begin
         sat = a_ws_ff;
         for (int k = 0; k < 3; k++) begin
            lim  = pn_ff[k] ? SMIN : SMAX;
            full = {prh_ff[k], {DW{1'b0}}} + (W2+FB)'(pr_ff[k]);
            sh   = W2'(full >> FB);
            if (a_d_ff == '0) begin
               out_g_ff[k] <= a_sep_ff[k];
            end else if (a_rg_ff == REGION_OUTSIDE) begin
               out_g_ff[k] <= '0;
            end else begin
               if (pz_ff[k] || czero_ff) m = '0;
               else if (chi_ff) begin m = lim; sat = 1'b1; end
               else if (sh > W2'(lim)) begin m = lim; sat = 1'b1; end
               else m = sh[DW-1:0];
               out_g_ff[k] <= pn_ff[k] ? (~m + 1'b1) : m;
            end
         end
         out_wt_ff  <= a_wt_ff;
         out_rg_ff  <= (a_d_ff == '0) ? REGION_ZERO : a_rg_ff;
         out_sat_ff <= sat;
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_kernel_weight = out_wt_ff;
   assign rsp_grad_x        = out_g_ff[0];
   assign rsp_grad_y        = out_g_ff[1];
   assign rsp_grad_z        = out_g_ff[2];
   assign rsp_region        = out_rg_ff;
   assign rsp_saturated     = out_sat_ff;
endmodule

FILE: rtl/core/sqsk_checker.sv
// Port-level checks for the quintic spline kernel, bound to the top level.
// Depends on sqsk_pkg and sph_quintic_spline_kernel.
module sqsk_checker import sqsk_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [DATA_WIDTH-1:0] rsp_kernel_weight,
   input logic [REG_W-1:0]      rsp_region,
   input logic                  rsp_saturated
);
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall)) else $error("request stalled without cause");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_kernel_weight)))
      else $error("stalled result changed");
   a_region_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_region <= REGION_ZERO)) else $error("bad region code");
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_region == REGION_OUTSIDE) |-> (rsp_kernel_weight == '0 &&
      !rsp_saturated)) else $error("outside support gave weight");
endmodule

bind sph_quintic_spline_kernel sqsk_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sqsk_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_kernel_weight(rsp_kernel_weight),
   .rsp_region(rsp_region), .rsp_saturated(rsp_saturated)
);

FILE: tb/tb_sph_quintic_spline_kernel.sv
// Testbench for sph_quintic_spline_kernel: drives particle pairs, predicts the
// quintic spline weight and gradient, and checks every result in order.
// Depends on sqsk_pkg and the kernel RTL.
module tb_sph_quintic_spline_kernel;
   import sqsk_pkg::*;

   localparam int DW = DATA_WIDTH_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam longint unsigned ONE = 64'd1 << FB;
   localparam logic [DW-1:0] FX_ONE = DW'(ONE);
   // pipe is 2*DW+20 deep; drain margin before csr writes and at the end
   localparam int DRAIN_CYCLES = 2 * DW + 40;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [DW-1:0] weight;
      logic [DW-1:0] gx;
      logic [DW-1:0] gy;
      logic [DW-1:0] gz;
      region_type    region;
      logic          sat;
   } kernel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [DW-1:0] req_pair_distance = '0;
   logic signed [DW-1:0] req_sep_x = '0, req_sep_y = '0, req_sep_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [DW-1:0] rsp_kernel_weight;
   logic signed [DW-1:0] rsp_grad_x, rsp_grad_y, rsp_grad_z;
   logic [REG_W-1:0] rsp_region;
   logic rsp_saturated;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [DW-1:0] pwdata = '0;
   logic [DW-1:0] prdata;
   logic pready;

   // shadow copies of the csr registers
   logic [DW-1:0] recip_len = DW'(ONE);
   logic [DW-1:0] wfact     = DW'(ONE);
   logic [DW-1:0] gfact     = DW'(5 * ONE);

   kernel_result_type expected_results[$];
   int  errors = 0;
   int  cycles = 0;
   int  send_gap_max = 14;   // sender idle range, 0 gives back-to-back requests
   int  recv_gap_max = 14;   // receiver stall range
   int  hold_request = 0;    // long receiver hold-off, counted by the stall process

   sph_quintic_spline_kernel DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pair_distance(req_pair_distance),
      .req_sep_x(req_sep_x), .req_sep_y(req_sep_y), .req_sep_z(req_sep_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kernel_weight(rsp_kernel_weight),
      .rsp_grad_x(rsp_grad_x), .rsp_grad_y(rsp_grad_y), .rsp_grad_z(rsp_grad_z),
      .rsp_region(rsp_region), .rsp_saturated(rsp_saturated),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Clock plus the run watchdog.
   initial begin
      forever begin
         #1 clock = ~clock;
         if (clock) begin
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
               $display("TEST FAILED");
               $finish;
            end
         end
      end
   end

   // x^4 and x^5 by repeated truncating fixed-point multiplies (64-bit wrap)
   function automatic void quint_powers(input longint unsigned x,
                                        output longint signed p4,
                                        output longint signed p5);
      longint unsigned acc;
      acc = (x * x) >> FB;
      acc = (acc * x) >> FB;
      acc = (acc * x) >> FB;
      p4 = longint'(acc);
      p5 = longint'((acc * x) >> FB);
   endfunction

   // Expected weight, gradient, region and saturation flag for one pair.
   function automatic kernel_result_type kernel_predict(logic [DW-1:0] pair_dist,
                                                        logic [DW-1:0] sx,
                                                        logic [DW-1:0] sy,
                                                        logic [DW-1:0] sz);
      kernel_result_type r;
      logic [63:0] qfull;
      longint unsigned q, gmag, smag4, smag, lim, m;
      longint signed s4, s5, a4, a5;
      logic [127:0] prod, coef;
      logic [DW-1:0] sep[3];
      logic [DW-1:0] g[3];
      logic cneg, sneg, neg;
      region_type reg_code;
      sep[0] = sx; sep[1] = sy; sep[2] = sz;
      g[0] = '0; g[1] = '0; g[2] = '0;
      r.sat = 1'b0;
      r.weight = '0;
      s4 = 0; s5 = 0;
      qfull = ({32'b0, pair_dist} * {32'b0, recip_len}) >> FB;
      if (qfull > ONE) begin
         reg_code = REGION_OUTSIDE;
         q = 0;
      end else begin
         q = qfull;
         reg_code = (3 * q < ONE) ? REGION_INNER :
                    (3 * q < 2 * ONE) ? REGION_MIDDLE : REGION_OUTER;
      end
      if (reg_code != REGION_OUTSIDE) begin
         quint_powers(ONE - q, s4, s5);
         if (reg_code != REGION_OUTER) begin
            quint_powers((2 * ONE) / 3 - q, a4, a5);
            s5 -= 6 * a5; s4 -= 6 * a4;
         end
         if (reg_code == REGION_INNER) begin
            quint_powers(ONE / 3 - q, a4, a5);
            s5 += 15 * a5; s4 += 15 * a4;
         end
         if (s5 < 0) begin
            r.sat = 1'b1;   // rounding drove the sum negative
         end else begin
            prod = (128'(wfact) * 128'(s5)) >> FB;
            if (prod > 128'({DW{1'b1}})) begin
               r.sat = 1'b1;
               r.weight = '1;
            end else begin
               r.weight = prod[DW-1:0];
            end
         end
      end
      if (pair_dist == 0) begin
         reg_code = REGION_ZERO;
         g = sep;
      end else if (reg_code != REGION_OUTSIDE) begin
         gmag  = gfact[DW-1] ? ((64'd1 << DW) - gfact) : gfact;
         smag4 = (s4 < 0) ? longint'(-s4) : longint'(s4);
         cneg  = gfact[DW-1] ^ (s4 < 0);
         coef  = (128'(gmag) * 128'(smag4)) / 128'(pair_dist);
         for (int k = 0; k < 3; k++) begin
            sneg = sep[k][DW-1];
            smag = sneg ? ((64'd1 << DW) - sep[k]) : sep[k];
            neg  = cneg ^ sneg;
            lim  = neg ? (64'd1 << (DW - 1)) : ((64'd1 << (DW - 1)) - 1);
            if (smag == 0 || coef == 0) begin
               m = 0;
            end else if (coef[127:64] != 0) begin
               r.sat = 1'b1;
               m = lim;
            end else begin
               prod = (coef * 128'(smag)) >> FB;
               if (prod > 128'(lim)) begin
                  r.sat = 1'b1;
                  m = lim;
               end else begin
                  m = prod[63:0];
               end
            end
            g[k] = neg ? DW'(-m) : DW'(m);
         end
      end
      r.gx = g[0]; r.gy = g[1]; r.gz = g[2];
      r.region = reg_code;
      return r;
   endfunction

   // Receiver stall: random gaps per result, plus a long hold when requested.
   initial begin
      int gap_left;
      int hold_left;
      gap_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (rsp_valid && !rsp_stall)
            gap_left = $urandom_range(0, recv_gap_max);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Result checker: compares each accepted result with the oldest prediction.
   initial begin
      kernel_result_type exp_r;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result weight=%h", $time, rsp_kernel_weight);
               errors++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_kernel_weight !== exp_r.weight) begin
                  $display("%0t: weight exp %h got %h", $time, exp_r.weight,
                           rsp_kernel_weight);
                  errors++;
               end
               if (rsp_grad_x !== exp_r.gx) begin
                  $display("%0t: grad_x exp %h got %h", $time, exp_r.gx, rsp_grad_x);
                  errors++;
               end
               if (rsp_grad_y !== exp_r.gy) begin
                  $display("%0t: grad_y exp %h got %h", $time, exp_r.gy, rsp_grad_y);
                  errors++;
               end
               if (rsp_grad_z !== exp_r.gz) begin
                  $display("%0t: grad_z exp %h got %h", $time, exp_r.gz, rsp_grad_z);
                  errors++;
               end
               if (rsp_region !== exp_r.region) begin
                  $display("%0t: region exp %0d got %0d", $time, exp_r.region,
                           rsp_region);
                  errors++;
               end
               if (rsp_saturated !== exp_r.sat) begin
                  $display("%0t: saturated exp %b got %b", $time, exp_r.sat,
                           rsp_saturated);
                  errors++;
               end
            end
         end
      end
   end

   // Offer one request; valid stays high into the next request when no gap.
   task automatic send_pair(logic [DW-1:0] pair_dist, logic [DW-1:0] sx,
                            logic [DW-1:0] sy, logic [DW-1:0] sz);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pair_distance <= pair_dist;
      req_sep_x <= sx; req_sep_y <= sy; req_sep_z <= sz;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(kernel_predict(pair_dist, sx, sy, sz));
   endtask

   // Drop valid, then wait for every prediction plus DRAIN_CYCLES.
   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready.
   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [DW-1:0] value);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= addr; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (addr)
         CSR_ADDR_W'(4 * CSR_RECIP): recip_len = value;
         CSR_ADDR_W'(4 * CSR_WFACT): wfact = value;
         CSR_ADDR_W'(4 * CSR_GFACT): gfact = value;
         default: ;  // unmapped: ignored
      endcase
      @(posedge clock);
   endtask

   task automatic set_kernel(logic [DW-1:0] rl, logic [DW-1:0] wf, logic [DW-1:0] gf);
      csr_write(CSR_ADDR_W'(4 * CSR_RECIP), rl);
      csr_write(CSR_ADDR_W'(4 * CSR_WFACT), wf);
      csr_write(CSR_ADDR_W'(4 * CSR_GFACT), gf);
   endtask

   function automatic logic [DW-1:0] rand_sep();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return DW'($urandom_range(0, 4 * ONE)) - DW'(2 * ONE);  // small values
         default: return $urandom;
      endcase
   endfunction

   // Distance mostly in 1..span, sometimes zero or anywhere.
   function automatic logic [DW-1:0] rand_dist(int unsigned span);
      if ($urandom_range(0, 9) == 0) return $urandom;
      if ($urandom_range(0, 19) == 0) return '0;
      return $urandom_range(1, span);
   endfunction

   // Region boundaries, zero distance, field extremes at reset settings.
   task automatic test_directed_regions();
      send_pair(0, 32'h8000_0000, 32'h7fff_ffff, 0);
      send_pair(0, 32'hffff_ffff, 32'h0001_0000, 32'h1234_5678);
      send_pair(1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
      send_pair(21845, FX_ONE, -FX_ONE, 0);          // last inner step
      send_pair(21846, FX_ONE, -FX_ONE, 3);          // first middle step
      send_pair(43690, FX_ONE, FX_ONE, FX_ONE);      // last middle
      send_pair(43691, -FX_ONE, FX_ONE, 7);          // first outer
      send_pair(FX_ONE, FX_ONE, FX_ONE, FX_ONE);     // q exactly one
      send_pair(FX_ONE + 1, FX_ONE, FX_ONE, FX_ONE); // just outside support
      send_pair(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1);
      send_pair(32'h8000_0000, FX_ONE, FX_ONE, FX_ONE);
      send_pair(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
      drain_pipe();
   endtask

   // Register extremes: zero and full reciprocal, huge/negative factors.
   task automatic test_csr_extremes();
      csr_write(4'hc, 32'hdead_beef);        // unmapped address, no effect
      set_kernel(0, 32'hffff_ffff, 32'h8000_0000);   // q is always 0
      send_pair(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 5);
      send_pair(1, 32'h7fff_ffff, -1, 1);
      send_pair(0, 1, 2, 3);
      drain_pipe();
      set_kernel(32'hffff_ffff, 0, 32'h7fff_ffff);
      send_pair(1, FX_ONE, -FX_ONE, 32'h7fff_ffff);
      send_pair(0, 9, 9, 9);
      send_pair(2, FX_ONE, FX_ONE, FX_ONE);
      send_pair(32'hffff_ffff, 1, 1, 1);
      drain_pipe();
      set_kernel(FX_ONE, FX_ONE, DW'(5 * ONE));
   endtask

   // Random pairs under one csr setting.
   task automatic test_random_phase(int count, logic [DW-1:0] rl, logic [DW-1:0] wf,
                                    logic [DW-1:0] gf, int unsigned span);
      set_kernel(rl, wf, gf);
      send_gap_max = $urandom_range(0, 1) ? 14 : 0;  // some phases back to back
      recv_gap_max = $urandom_range(0, 1) ? 14 : 0;
      repeat (count) send_pair(rand_dist(span), rand_sep(), rand_sep(), rand_sep());
      drain_pipe();
      send_gap_max = 14;
      recv_gap_max = 14;
   endtask

   // Receiver holds off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      send_gap_max = 0;
      hold_request = 300;
      repeat (120) send_pair(rand_dist(80000), rand_sep(), rand_sep(), rand_sep());
      drain_pipe();
      send_gap_max = 14;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_regions();
      test_csr_extremes();
      test_random_phase(120, FX_ONE, FX_ONE, DW'(5 * ONE), 80000);
      test_random_phase(80, DW'(4 * ONE), DW'(3 * ONE), -DW'(7 * ONE), 20000);
      test_random_phase(60, DW'(ONE / 8), $urandom, $urandom, 600000);
      test_random_phase(60, $urandom_range(1, 2 * ONE), $urandom, $urandom, 200000);
      test_random_phase(40, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 4);
      test_backpressure();
      test_random_phase(60, FX_ONE, 32'h0100_0000, 32'h7fff_ffff, 80000);
      drain_pipe();
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

FILE: sim.f
rtl/core/sqsk_pkg.sv
rtl/core/sqsk_divider.sv
rtl/core/sph_quintic_spline_kernel.sv
rtl/core/sqsk_checker.sv
tb/tb_sph_quintic_spline_kernel.sv
